// ===== design/iwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwm_pkg
// Shared types and constants of the intensity window mapper.
// ----------------------------------------------------------------------------
package iwm_pkg;

    // Pixel precision; only the low PIXEL_BITS of a pixel take part.
    localparam int PIXEL_BITS = 16;
    localparam logic [15:0] PIX_MASK = 16'((32'd1 << PIXEL_BITS) - 32'd1);

    // Front-to-back job queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = 16;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // Percent scaling: x / 100 == (x * PCT_RECIP) >> PCT_SHIFT for x < 2^23
    localparam logic [6:0]  PCT_FULL  = 7'd100;
    localparam logic [23:0] PCT_RECIP = 24'd10737419;
    localparam int          PCT_SHIFT = 30;

    // Register file
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_LOW_LEVEL  = 3'd1;
    localparam logic [2:0] REG_HIGH_LEVEL = 3'd2;
    localparam logic [2:0] REG_LOW_OUT    = 3'd3;
    localparam logic [2:0] REG_HIGH_OUT   = 3'd4;
    localparam logic [2:0] REG_CONTRAST   = 3'd5;
    localparam logic [2:0] REG_BRIGHTNESS = 3'd6;
    localparam logic [2:0] REG_OUT_MAX    = 3'd7;

    // Commands
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_MAP     = 1'b1;

    typedef enum logic [1:0] {
        MODE_EXPLICIT = 2'd0,
        MODE_NEGATIVE = 2'd1,
        MODE_NORMALIZE = 2'd2,
        MODE_CONTRAST = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] low_level;
        logic [15:0] high_level;
        logic [15:0] low_out;
        logic [15:0] high_out;
        logic [6:0]  contrast_pct;
        logic [6:0]  brightness_pct;
        logic [15:0] out_max;
    } cfg_t;

    // A map job with the frame statistics seen when it arrived
    typedef struct packed {
        logic [15:0] pixel;
        logic [15:0] fmin;
        logic [15:0] fmax;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL_L,
        B_SCL_L,
        B_MUL_W,
        B_SCL_W,
        B_WINDOW,
        B_CMP,
        B_MUL_M,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

// ===== design/iwm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwm_front
// Accepts pixel transfers, tracks frame min/max and queues map jobs.
// ----------------------------------------------------------------------------
module iwm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pix_valid,
    output logic          pix_stall,
    input  logic          command,
    input  logic [15:0]   pixel_value,
    input  logic          first_of_frame,
    input  logic          q_full,
    output logic          q_push,
    output iwm_pkg::job_t q_job
);
    import iwm_pkg::*;

    logic [15:0] fmin_reg, fmin_next;
    logic [15:0] fmax_reg, fmax_next;
    logic [15:0] pix;
    logic        take;

    assign pix       = pixel_value & PIX_MASK;
    assign pix_stall = q_full;
    assign take      = pix_valid && !q_full;
    assign q_push    = take && (command == CMD_MAP);
    assign q_job     = '{pixel: pix, fmin: fmin_reg, fmax: fmax_reg};

    always_comb
    begin
        fmin_next = fmin_reg;
        fmax_next = fmax_reg;
        if (take && (command == CMD_MEASURE))
        begin
            if (first_of_frame)
            begin
                fmin_next = pix;
                fmax_next = pix;
            end
            else
            begin
                if (pix < fmin_reg)
                    fmin_next = pix;
                if (pix > fmax_reg)
                    fmax_next = pix;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmin_reg <= 16'hFFFF;
            fmax_reg <= 16'h0000;
        end
        else
        begin
            fmin_reg <= fmin_next;
            fmax_reg <= fmax_next;
        end
    end

endmodule

// ===== design/iwm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwm_queue
// Short FIFO of map jobs between the front and the back.
// ----------------------------------------------------------------------------
module iwm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  iwm_pkg::job_t wr_job,
    input  logic          pop,
    output iwm_pkg::job_t rd_job,
    output logic          full,
    output logic          empty
);
    import iwm_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

// ===== design/iwm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwm_back
// Window setup, linear map with shared multiplier and serial divider,
// result register.
// ----------------------------------------------------------------------------
module iwm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  iwm_pkg::cfg_t cfg,
    input  logic          q_empty,
    input  iwm_pkg::job_t q_job,
    output logic          q_pop,
    output logic          res_valid,
    input  logic          res_stall,
    output logic [15:0]   mapped_value
);
    import iwm_pkg::*;

    back_state_t state_reg, state_next;

    job_t               job_reg;
    logic [46:0]        prod_reg;
    logic [15:0]        level_reg;
    logic signed [17:0] l1_reg;
    logic signed [17:0] l2_reg;
    logic [15:0]        k1_reg;
    logic [15:0]        k2_reg;
    logic [15:0]        base_reg;
    logic [15:0]        num_reg;
    logic [15:0]        den_reg;
    logic [15:0]        mag_reg;
    logic               neg_reg;
    logic [15:0]        rem_reg;
    logic [15:0]        low_reg;
    logic [DCNT_W-1:0]  cnt_reg;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_data_reg;

    logic [15:0]        rng;
    logic [6:0]         c_sat;
    logic [6:0]         b_inv;
    logic [15:0]        h_top;
    logic [15:0]        quot_pct;
    logic [15:0]        half_w;
    logic signed [17:0] v18;
    logic signed [17:0] num_full;
    logic signed [17:0] den_full;
    logic               win_lo;
    logic               win_hi;
    logic [16:0]        shifted;
    logic [16:0]        sub;
    logic               ge;
    logic [15:0]        result;
    logic               ld;
    logic [22:0]        mul_a;
    logic [23:0]        mul_b;
    logic [46:0]        mul_p;

    // Window setup terms
    assign rng      = (job_reg.fmax > job_reg.fmin) ? job_reg.fmax - job_reg.fmin : '0;
    assign c_sat    = (cfg.contrast_pct > PCT_FULL) ? PCT_FULL : cfg.contrast_pct;
    assign b_inv    = PCT_FULL - ((cfg.brightness_pct > PCT_FULL) ? PCT_FULL
                                                                  : cfg.brightness_pct);
    assign h_top    = (cfg.out_max != '0) ? cfg.out_max : job_reg.fmax;
    assign quot_pct = prod_reg[PCT_SHIFT +: 16];
    assign half_w   = {1'b0, quot_pct[15:1]};

    // Window compare
    assign v18      = $signed({2'b00, job_reg.pixel});
    assign win_lo   = v18 < l1_reg;
    assign win_hi   = v18 >= l2_reg;
    assign num_full = v18 - l1_reg;
    assign den_full = l2_reg - l1_reg;

    // Restoring divide step; remainder always stays below the divisor
    assign shifted = {rem_reg, low_reg[15]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign sub     = shifted - {1'b0, den_reg};

    // Quotient is below |k2 - k1|, so the sum stays between k1 and k2
    assign result = neg_reg ? base_reg - low_reg : base_reg + low_reg;

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!q_empty)
                    state_next = (cfg.mode == MODE_CONTRAST) ? B_MUL_L : B_WINDOW;
            B_MUL_L:  state_next = B_SCL_L;
            B_SCL_L:  state_next = B_MUL_W;
            B_MUL_W:  state_next = B_SCL_W;
            B_SCL_W:  state_next = B_WINDOW;
            B_WINDOW: state_next = B_CMP;
            B_CMP:    state_next = (win_lo || win_hi) ? B_DONE : B_MUL_M;
            B_MUL_M:  state_next = B_DIV;
            B_DIV:
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                    state_next = B_DONE;
            B_DONE:
                if (ld)
                    state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = 1'b0;
        ld    = 1'b0;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            B_IDLE:
                q_pop = !q_empty;
            B_MUL_L:
            begin
                mul_a = 23'(b_inv);
                mul_b = 24'(rng);
            end
            B_MUL_W:
            begin
                mul_a = 23'(c_sat);
                mul_b = 24'(rng);
            end
            B_SCL_L, B_SCL_W:
            begin
                mul_a = prod_reg[22:0];
                mul_b = PCT_RECIP;
            end
            B_MUL_M:
            begin
                mul_a = 23'(num_reg);
                mul_b = 24'(mag_reg);
            end
            B_DONE:
                ld = !out_valid_reg || !res_stall;
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !res_stall)
            out_valid_next = 1'b0;
        if (ld)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
                if (q_pop)
                    job_reg <= q_job;
            B_MUL_L, B_SCL_L, B_SCL_W:
                prod_reg <= mul_p;
            B_MUL_W:
            begin
                level_reg <= job_reg.fmin + quot_pct;
                prod_reg  <= mul_p;
            end
            B_WINDOW:
            begin
                case (cfg.mode)
                    MODE_EXPLICIT:
                    begin
                        l1_reg <= $signed({2'b00, cfg.low_level});
                        l2_reg <= $signed({2'b00, cfg.high_level});
                        k1_reg <= cfg.low_out;
                        k2_reg <= cfg.high_out;
                    end
                    MODE_NEGATIVE:
                    begin
                        l1_reg <= $signed({2'b00, job_reg.fmin});
                        l2_reg <= $signed({2'b00, job_reg.fmax});
                        k1_reg <= job_reg.fmax;
                        k2_reg <= job_reg.fmin;
                    end
                    MODE_NORMALIZE:
                    begin
                        l1_reg <= $signed({2'b00, job_reg.fmin});
                        l2_reg <= $signed({2'b00, job_reg.fmax});
                        k1_reg <= '0;
                        k2_reg <= h_top;
                    end
                    default:
                    begin
                        l1_reg <= $signed({2'b00, level_reg}) - $signed({2'b00, half_w});
                        l2_reg <= $signed({2'b00, level_reg}) + $signed({2'b00, half_w});
                        k1_reg <= '0;
                        k2_reg <= h_top;
                    end
                endcase
            end
            B_CMP:
            begin
                base_reg <= (!win_lo && win_hi) ? k2_reg : k1_reg;
                low_reg  <= '0;
                num_reg  <= num_full[15:0];
                den_reg  <= den_full[15:0];
                neg_reg  <= k2_reg < k1_reg;
                mag_reg  <= (k2_reg < k1_reg) ? k1_reg - k2_reg : k2_reg - k1_reg;
            end
            B_MUL_M:
            begin
                rem_reg <= mul_p[31:16];
                low_reg <= mul_p[15:0];
                cnt_reg <= '0;
            end
            B_DIV:
            begin
                rem_reg <= ge ? sub[15:0] : shifted[15:0];
                low_reg <= {low_reg[14:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            B_DONE:
                if (ld)
                    out_data_reg <= result;
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign res_valid    = out_valid_reg;
    assign mapped_value = out_data_reg;

endmodule

// ===== design/intensity_window_mapper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intensity_window_mapper_core
// Two-pass window/level contrast stretch: measure pixels for frame min/max,
// then map pixels through an explicit, negative, normalize or
// contrast/brightness window.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------
//  config   | in/out    | psel, penable, pready   | paddr, pwrite, pwdata, prdata
//  pixel    | in        | pix_valid / pix_stall   | command, pixel_value,
//           |           |                         | first_of_frame
//  result   | out       | res_valid / res_stall   | mapped_value
//
// Measure transfers are taken one per cycle while the job queue has room.
// In the back, a map job whose pixel lies inside the window runs window setup,
// compare, a multiply and the serial divider, plus level and width scaling
// in contrast mode; a pixel outside the window skips multiply and divider.
// Four map jobs queue between front and back, so the front stalls only when
// the queue is full; a finished result waits in its own output register.
// Reset restores the register defaults and clears frame min/max tracking.
// ----------------------------------------------------------------------------
module intensity_window_mapper_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [iwm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        pix_valid,
    output logic                        pix_stall,
    input  logic                        command,
    input  logic [15:0]                 pixel_value,
    input  logic                        first_of_frame,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [15:0]                 mapped_value
);
    import iwm_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    job_t       wr_job;
    job_t       rd_job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MODE:       cfg_next.mode           = mode_t'(pwdata[1:0]);
                REG_LOW_LEVEL:  cfg_next.low_level      = pwdata[15:0];
                REG_HIGH_LEVEL: cfg_next.high_level     = pwdata[15:0];
                REG_LOW_OUT:    cfg_next.low_out        = pwdata[15:0];
                REG_HIGH_OUT:   cfg_next.high_out       = pwdata[15:0];
                REG_CONTRAST:   cfg_next.contrast_pct   = pwdata[6:0];
                REG_BRIGHTNESS: cfg_next.brightness_pct = pwdata[6:0];
                REG_OUT_MAX:    cfg_next.out_max        = pwdata[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODE:       prdata = 32'(cfg_reg.mode);
            REG_LOW_LEVEL:  prdata = 32'(cfg_reg.low_level);
            REG_HIGH_LEVEL: prdata = 32'(cfg_reg.high_level);
            REG_LOW_OUT:    prdata = 32'(cfg_reg.low_out);
            REG_HIGH_OUT:   prdata = 32'(cfg_reg.high_out);
            REG_CONTRAST:   prdata = 32'(cfg_reg.contrast_pct);
            REG_BRIGHTNESS: prdata = 32'(cfg_reg.brightness_pct);
            REG_OUT_MAX:    prdata = 32'(cfg_reg.out_max);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= MODE_EXPLICIT;
            cfg_reg.low_level      <= 16'd0;
            cfg_reg.high_level     <= 16'd65535;
            cfg_reg.low_out        <= 16'd0;
            cfg_reg.high_out       <= 16'd65535;
            cfg_reg.contrast_pct   <= 7'd50;
            cfg_reg.brightness_pct <= 7'd50;
            cfg_reg.out_max        <= 16'd255;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    iwm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_valid      (pix_valid),
        .pix_stall      (pix_stall),
        .command        (command),
        .pixel_value    (pixel_value),
        .first_of_frame (first_of_frame),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_job          (wr_job)
    );

    iwm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_job (wr_job),
        .pop    (q_pop),
        .rd_job (rd_job),
        .full   (q_full),
        .empty  (q_empty)
    );

    iwm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_job        (rd_job),
        .q_pop        (q_pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .mapped_value (mapped_value)
    );

    // Front must never push a job into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("map job pushed into full queue");

    // Back must never pop from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_empty))
        else $error("map job popped from empty queue");

    // After any measure transfer the tracked range is well ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall && (command == CMD_MEASURE))
            |=> (wr_job.fmin <= wr_job.fmax))
        else $error("frame minimum above maximum after measure");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for intensity_window_mapper_core. A directed table
// covers reset defaults, the four window modes, percent saturation, empty,
// inverted and out-of-range windows. It is followed by random frames
// (measure pass, then map pass) and mixed transfers under changing register
// settings. Every mapped value is compared with its directed expectation or
// with a behavioural model of the window arithmetic kept in this bench.
// ----------------------------------------------------------------------------
module tb;
    import iwm_pkg::*;

    localparam int     SEGMENTS      = 15;
    localparam int     SEG_ITEMS     = 90;
    localparam int     SETTLE_CYCLES = 64;
    localparam int     WATCHDOG      = 2000;
    localparam longint PCT_SCALE     = 100;

    typedef enum logic {
        ROW_WRITE,
        ROW_PIXEL
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [31:0] data;
        logic        cmd;
        logic [15:0] pix;
        logic        first;
        bit          typed;
        logic [15:0] want;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                pix_valid;
    logic                pix_stall;
    logic                command;
    logic [15:0]         pixel_value;
    logic                first_of_frame;
    logic                res_valid;
    logic                res_stall;
    logic [15:0]         mapped_value;

    // Shadow of the register file and the frame statistics
    cfg_t        regs;
    logic [15:0] frame_lo;
    logic [15:0] frame_hi;

    logic [15:0] mapped_due[$];
    row_t        plan[$];
    logic [15:0] due_now;
    int          errors;
    int          quiet;
    int          send_idle_pct;
    int          recv_idle_pct;

    intensity_window_mapper_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .pix_valid      (pix_valid),
        .pix_stall      (pix_stall),
        .command        (command),
        .pixel_value    (pixel_value),
        .first_of_frame (first_of_frame),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .mapped_value   (mapped_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected mapped value of one pixel under the current window
    function automatic logic [15:0] window_map(input logic [15:0] pix);
        longint v, mn, mx, h, l1, l2, k1, k2;
        longint rng, c, b, lvl, wd, r, lo, hi;
        v  = pix & PIX_MASK;
        mn = frame_lo;
        mx = frame_hi;
        h  = regs.out_max;
        if (regs.out_max == 16'd0)
            h = mx;
        case (regs.mode)
            MODE_EXPLICIT:
            begin
                l1 = regs.low_level;
                l2 = regs.high_level;
                k1 = regs.low_out;
                k2 = regs.high_out;
            end
            MODE_NEGATIVE:
            begin
                l1 = mn;
                l2 = mx;
                k1 = mx;
                k2 = mn;
            end
            MODE_NORMALIZE:
            begin
                l1 = mn;
                l2 = mx;
                k1 = 0;
                k2 = h;
            end
            default:
            begin
                rng = (mx > mn) ? mx - mn : 0;
                c   = regs.contrast_pct;
                b   = regs.brightness_pct;
                if (c > PCT_SCALE)
                    c = PCT_SCALE;
                if (b > PCT_SCALE)
                    b = PCT_SCALE;
                lvl = mn + ((PCT_SCALE - b) * rng) / PCT_SCALE;
                wd  = (c * rng) / PCT_SCALE;
                l1  = lvl - wd / 2;
                l2  = lvl + wd / 2;
                k1  = 0;
                k2  = h;
            end
        endcase
        if (v < l1)
            r = k1;
        else if (v >= l2)
            r = k2;
        else
        begin
            r  = k1 + ((v - l1) * (k2 - k1)) / (l2 - l1);
            lo = (k1 < k2) ? k1 : k2;
            hi = (k1 < k2) ? k2 : k1;
            if (r < lo)
                r = lo;
            if (r > hi)
                r = hi;
        end
        return 16'(r);
    endfunction

    function automatic logic [31:0] rand_reg_value(input logic [2:0] idx);
        logic [31:0] val;
        case (idx)
            REG_MODE:
                val = $urandom_range(3);
            REG_CONTRAST, REG_BRIGHTNESS:
            begin
                case ($urandom_range(7))
                    0:       val = 0;
                    1:       val = 100;
                    2:       val = 101;
                    3:       val = 127;
                    default: val = $urandom_range(100);
                endcase
            end
            REG_OUT_MAX:
            begin
                case ($urandom_range(5))
                    0, 1:    val = 0;
                    2:       val = 65535;
                    default: val = $urandom_range(65535);
                endcase
            end
            default:
            begin
                case ($urandom_range(7))
                    0:       val = 0;
                    1:       val = 65535;
                    default: val = $urandom_range(65535);
                endcase
            end
        endcase
        return val;
    endfunction

    function automatic void plan_write(input logic [2:0] idx, input logic [31:0] data);
        row_t row;
        row       = '{kind: ROW_WRITE, default: '0};
        row.idx   = idx;
        row.data  = data;
        plan.push_back(row);
    endfunction

    function automatic void plan_pixel(input logic cmd, input logic [15:0] pix,
                                       input logic first, input bit typed,
                                       input logic [15:0] want);
        row_t row;
        row       = '{kind: ROW_PIXEL, default: '0};
        row.cmd   = cmd;
        row.pix   = pix;
        row.first = first;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_MODE:       regs.mode           = mode_t'(val[1:0]);
            REG_LOW_LEVEL:  regs.low_level      = val[15:0];
            REG_HIGH_LEVEL: regs.high_level     = val[15:0];
            REG_LOW_OUT:    regs.low_out        = val[15:0];
            REG_HIGH_OUT:   regs.high_out       = val[15:0];
            REG_CONTRAST:   regs.contrast_pct   = val[6:0];
            REG_BRIGHTNESS: regs.brightness_pct = val[6:0];
            default:        regs.out_max        = val[15:0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid and hold until every mapped value is back
    task automatic wait_idle(input bit settle);
        @(negedge clk);
        pix_valid <= 1'b0;
        while (mapped_due.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixel(input logic cmd, input logic [15:0] pix, input logic first,
                              input bit typed, input logic [15:0] want);
        logic [15:0] p;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid      <= 1'b1;
        command        <= cmd;
        pixel_value    <= pix;
        first_of_frame <= first;
        do
            @(posedge clk);
        while (pix_stall);
        p = pix & PIX_MASK;
        if (cmd == CMD_MAP)
            mapped_due.push_back(typed ? want : window_map(p));
        else if (first)
        begin
            frame_lo = p;
            frame_hi = p;
        end
        else
        begin
            if (p < frame_lo)
                frame_lo = p;
            if (p > frame_hi)
                frame_hi = p;
        end
    endtask

    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result checker and watchdog
    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
        begin
            if (mapped_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual mapped_value=%0d",
                         $time, mapped_value);
                errors++;
            end
            else
            begin
                due_now = mapped_due.pop_front();
                if (mapped_value !== due_now)
                begin
                    $display("%0t: mapped_value mismatch, expected %0d, actual %0d",
                             $time, due_now, mapped_value);
                    errors++;
                end
            end
        end
        if ((pix_valid && !pix_stall) || (res_valid && !res_stall)
            || (psel && penable && pwrite && pready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int          sent;
        int          centre;
        int          spread;
        int          lo;
        int          hi;
        int          n_meas;
        int          n_map;
        logic [15:0] pix;

        clk            = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        pix_valid      = 1'b0;
        command        = CMD_MEASURE;
        pixel_value    = '0;
        first_of_frame = 1'b0;
        res_stall      = 1'b0;
        errors         = 0;
        quiet          = 0;
        send_idle_pct  = 13;
        recv_idle_pct  = 53;
        regs           = '{MODE_EXPLICIT, 16'd0, 16'd65535, 16'd0, 16'd65535,
                           7'd50, 7'd50, 16'd255};
        frame_lo       = 16'hFFFF;
        frame_hi       = 16'h0000;

        // Reset window is the identity
        plan_pixel(CMD_MAP, 16'd0, 1'b0, 1'b1, 16'd0);
        plan_pixel(CMD_MAP, 16'd65535, 1'b1, 1'b1, 16'd65535);
        plan_pixel(CMD_MAP, 16'h8000, 1'b0, 1'b1, 16'h8000);
        // Contrast mode before any measurement: zero range, window at 65535
        plan_write(REG_MODE, 32'(MODE_CONTRAST));
        plan_pixel(CMD_MAP, 16'd0, 1'b0, 1'b1, 16'd0);
        plan_pixel(CMD_MAP, 16'd65535, 1'b0, 1'b1, 16'd255);
        // Measure pass: restart, then update in place to full range
        plan_pixel(CMD_MEASURE, 16'h1234, 1'b1, 1'b0, '0);
        plan_pixel(CMD_MEASURE, 16'hFFFF, 1'b0, 1'b0, '0);
        plan_pixel(CMD_MEASURE, 16'h0000, 1'b0, 1'b0, '0);
        plan_pixel(CMD_MEASURE, 16'hA5A5, 1'b0, 1'b0, '0);
        plan_pixel(CMD_MEASURE, 16'h5A5A, 1'b0, 1'b0, '0);
        // Half contrast, half brightness: window 16384..49150
        plan_pixel(CMD_MAP, 16'd16383, 1'b0, 1'b1, 16'd0);
        plan_pixel(CMD_MAP, 16'd49150, 1'b0, 1'b1, 16'd255);
        plan_pixel(CMD_MAP, 16'd32768, 1'b0, 1'b0, '0);
        // Saturated percentages put the window edge below zero
        plan_write(REG_CONTRAST, 32'd127);
        plan_write(REG_BRIGHTNESS, 32'd127);
        plan_pixel(CMD_MAP, 16'd0, 1'b0, 1'b0, '0);
        plan_pixel(CMD_MAP, 16'd40000, 1'b0, 1'b1, 16'd255);
        // Zero width: empty window
        plan_write(REG_CONTRAST, 32'd0);
        plan_write(REG_BRIGHTNESS, 32'd101);
        plan_pixel(CMD_MAP, 16'd0, 1'b0, 1'b1, 16'd255);
        plan_write(REG_MODE, 32'(MODE_NEGATIVE));
        plan_pixel(CMD_MAP, 16'd0, 1'b0, 1'b1, 16'd65535);
        plan_pixel(CMD_MAP, 16'd65535, 1'b0, 1'b1, 16'd0);
        plan_pixel(CMD_MAP, 16'd1000, 1'b0, 1'b0, '0);
        // Normalize to the frame maximum
        plan_pixel(CMD_MEASURE, 16'd1000, 1'b1, 1'b0, '0);
        plan_pixel(CMD_MEASURE, 16'd3000, 1'b0, 1'b0, '0);
        plan_write(REG_MODE, 32'(MODE_NORMALIZE));
        plan_write(REG_OUT_MAX, 32'd0);
        plan_pixel(CMD_MAP, 16'd999, 1'b0, 1'b1, 16'd0);
        plan_pixel(CMD_MAP, 16'd3000, 1'b0, 1'b1, 16'd3000);
        plan_pixel(CMD_MAP, 16'd2000, 1'b0, 1'b0, '0);
        // Inverted explicit window
        plan_write(REG_MODE, 32'(MODE_EXPLICIT));
        plan_write(REG_LOW_LEVEL, 32'd40000);
        plan_write(REG_HIGH_LEVEL, 32'd1000);
        plan_write(REG_LOW_OUT, 32'd65535);
        plan_write(REG_HIGH_OUT, 32'd0);
        plan_pixel(CMD_MAP, 16'd39999, 1'b0, 1'b1, 16'd65535);
        plan_pixel(CMD_MAP, 16'd40000, 1'b0, 1'b1, 16'd0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                wait_idle(1);
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send_pixel(plan[i].cmd, plan[i].pix, plan[i].first,
                           plan[i].typed, plan[i].want);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            send_idle_pct = (seg < 5) ? 13 : (seg < 10) ? 53 : 0;
            recv_idle_pct = (seg < 5) ? 53 : (seg < 10) ? 13 : 0;
            wait_idle(1);
            for (int r = 0; r < 8; r++)
                write_reg(3'(r), rand_reg_value(3'(r)));
            sent = 0;
            while (sent < SEG_ITEMS)
            begin
                if ($urandom_range(99) < 85)
                begin
                    centre = $urandom_range(65535);
                    case ($urandom_range(3))
                        0:       spread = 0;
                        1:       spread = 16;
                        2:       spread = 2000;
                        default: spread = 65535;
                    endcase
                    lo     = (centre > spread) ? centre - spread : 0;
                    hi     = (centre + spread > 65535) ? 65535 : centre + spread;
                    n_meas = $urandom_range(16, 1);
                    for (int k = 0; k < n_meas; k++)
                        send_pixel(CMD_MEASURE, 16'($urandom_range(hi, lo)), k == 0,
                                   1'b0, '0);
                    n_map = $urandom_range(24, 4);
                    for (int k = 0; k < n_map; k++)
                    begin
                        case ($urandom_range(3))
                            0, 1:    pix = 16'($urandom_range(frame_hi, frame_lo));
                            2:       pix = 16'($urandom_range(65535));
                            default:
                            begin
                                case ($urandom_range(5))
                                    0:       pix = 16'd0;
                                    1:       pix = 16'd65535;
                                    2:       pix = frame_lo;
                                    3:       pix = frame_hi;
                                    4:       pix = frame_lo + 16'd1;
                                    default: pix = frame_hi - 16'd1;
                                endcase
                            end
                        endcase
                        send_pixel(CMD_MAP, pix, 1'($urandom_range(1)), 1'b0, '0);
                    end
                    sent += n_meas + n_map;
                    // Now and then let the pipeline run dry mid-segment
                    if ($urandom_range(24) == 0)
                        wait_idle(0);
                end
                else
                begin
                    for (int k = 0; k < 8; k++)
                        send_pixel(1'($urandom_range(1)), 16'($urandom_range(65535)),
                                   ($urandom_range(3) == 0), 1'b0, '0);
                    sent += 8;
                end
            end
        end

        wait_idle(1);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
